// ===== rtl/rgme_pkg.sv =====
// Shared types and constants for the range-gated multirate EWMA block.
// Register indexes, field widths and reset values; no dependencies.
`timescale 1ns / 1ps

package rgme_pkg;

  // Default widths of the distance and timestamp fields
  localparam int DIST_BITS_DEF = 20;
  localparam int TIME_BITS_DEF = 32;

  // Configuration register widths
  localparam int RANGE_W    = 20;
  localparam int TAU_W      = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  // Register reset values
  localparam logic [RANGE_W-1:0] MAX_RANGE_RST = RANGE_W'(5120);
  localparam logic [RANGE_W-1:0] MIN_RANGE_RST = RANGE_W'(1);
  localparam logic [TAU_W-1:0]   TAU_RST       = TAU_W'(100000);
  localparam logic [TAU_W-1:0]   TIMEOUT_RST   = TAU_W'(250000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_RANGE  = 2'd0,
    REG_MIN_RANGE  = 2'd1,
    REG_TIME_CONST = 2'd2,
    REG_TIMEOUT    = 2'd3
  } cfg_reg_t;

endpackage

// ===== rtl/range_gated_multirate_ewma.sv =====
// Range-gated EWMA of a distance with a variable time step.
// An out-of-range sample or a filter restart goes from decode straight to the output
// register; a filtered sample first passes the multiply state and the bit-serial divider
// that forms diff*dt/(tau+dt). One item at a time: a new item is accepted only once the
// last has entered the output register, so an output stall also holds off the input.
// Reset (synchronous, rst_n low) clears the filter state and loads register defaults.
`timescale 1ns / 1ps

module range_gated_multirate_ewma #(
  parameter int DIST_BITS = rgme_pkg::DIST_BITS_DEF,
  parameter int TIME_BITS = rgme_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [rgme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgme_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [DIST_BITS-1:0]            in_distance,
  input  logic [TIME_BITS-1:0]            in_now_us,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_valid_res,
  output logic [DIST_BITS-1:0]            out_value,
  output logic [DIST_BITS-1:0]            out_filtered
);

  import rgme_pkg::*;

  // Compare widths: distance vs. 20-bit bounds, and dt vs. 24-bit timeout
  localparam int RNG_W = (DIST_BITS > RANGE_W) ? DIST_BITS : RANGE_W;
  localparam int CMP_W = (TIME_BITS > TAU_W) ? TIME_BITS : TAU_W;
  // Product |diff| * dt, and divisor tau + dt
  localparam int NUM_W = DIST_BITS + TAU_W;
  localparam int DEN_W = TAU_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [RANGE_W-1:0] max_range_r;
  logic [RANGE_W-1:0] min_range_r;
  logic [TAU_W-1:0]   tau_r;
  logic [TAU_W-1:0]   timeout_r;

  // Filter state
  logic                 valid_flag_r;
  logic [DIST_BITS-1:0] last_value_r;
  logic [DIST_BITS-1:0] filtered_r;
  logic [TIME_BITS-1:0] last_time_r;

  // Working registers for the filtered path
  logic [DIST_BITS-1:0] mag_r;
  logic                 neg_r;
  logic [TAU_W-1:0]     dt_r;
  logic [NUM_W-1:0]     num_r;
  logic [DEN_W-1:0]     den_r;
  logic                 div_start_r;

  // Output register
  logic                 out_valid_r;
  logic                 out_valid_res_r;
  logic [DIST_BITS-1:0] out_value_r;
  logic [DIST_BITS-1:0] out_filtered_r;

  // Combinational decode of the incoming sample
  logic                 accept;
  logic [RNG_W-1:0]     dist_ext;
  logic                 in_range;
  logic [TIME_BITS-1:0] dt;
  logic [CMP_W-1:0]     dt_ext;
  logic                 restart;
  logic [DIST_BITS-1:0] mag;
  logic                 neg;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quo;
  logic [DIST_BITS-1:0] step;
  logic                 out_free;

  assign accept   = in_valid && in_ready;
  assign dist_ext = RNG_W'(in_distance);
  assign in_range = (dist_ext < RNG_W'(max_range_r)) && (dist_ext > RNG_W'(min_range_r));
  assign dt       = in_now_us - last_time_r;
  assign dt_ext   = CMP_W'(dt);
  assign restart  = !valid_flag_r || (dt == '0) || (dt_ext >= CMP_W'(timeout_r)) ||
                    (tau_r == '0);
  assign neg      = in_distance < filtered_r;
  assign mag      = neg ? (filtered_r - in_distance) : (in_distance - filtered_r);
  // Quotient never exceeds |diff|, so its low bits carry all of it
  assign step     = div_quo[DIST_BITS-1:0];
  assign out_free = !out_valid_r || out_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_range_r <= MAX_RANGE_RST;
      min_range_r <= MIN_RANGE_RST;
      tau_r       <= TAU_RST;
      timeout_r   <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_RANGE:  max_range_r <= cfg_wdata[RANGE_W-1:0];
        REG_MIN_RANGE:  min_range_r <= cfg_wdata[RANGE_W-1:0];
        REG_TIME_CONST: tau_r       <= cfg_wdata[TAU_W-1:0];
        REG_TIMEOUT:    timeout_r   <= cfg_wdata[TAU_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: decode, multiply and divide if filtered, then load the output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_flag_r <= 1'b0;
      last_value_r <= '0;
      filtered_r   <= '0;
      last_time_r  <= '0;
      div_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      div_start_r <= (state_r == S_MUL);
      // load a finished item, or drop the one the receiver took
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (!in_range) begin
              // out-of-range sample: drop the valid flag, keep everything else
              valid_flag_r <= 1'b0;
              state_r      <= S_FIN;
            end else begin
              valid_flag_r <= 1'b1;
              last_value_r <= in_distance;
              last_time_r  <= in_now_us;
              if (restart) begin
                filtered_r <= in_distance;
                state_r    <= S_FIN;
              end else begin
                state_r <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            // advance toward the sample, rounding toward zero
            filtered_r <= neg_r ? (filtered_r - step) : (filtered_r + step);
            state_r    <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload registers of the working path and the output stage
  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r <= mag;
      neg_r <= neg;
      dt_r  <= dt_ext[TAU_W-1:0];
    end
    if (state_r == S_MUL) begin
      num_r <= NUM_W'(mag_r) * NUM_W'(dt_r);
      den_r <= DEN_W'(tau_r) + DEN_W'(dt_r);
    end
    if (state_r == S_FIN && out_free) begin
      out_valid_res_r <= valid_flag_r;
      out_value_r     <= last_value_r;
      out_filtered_r  <= filtered_r;
    end
  end

  rgme_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start_r),
    .num  (num_r),
    .den  (den_r),
    .done (div_done),
    .quo  (div_quo)
  );

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_valid_res = out_valid_res_r;
  assign out_value     = out_value_r;
  assign out_filtered  = out_filtered_r;

endmodule

// ===== rtl/rgme_div.sv =====
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Used by the EWMA sequencer for the weighted step; no package needed.
`timescale 1ns / 1ps

module rgme_div #(
  parameter int NUM_W = 44,
  parameter int DEN_W = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  // Shift in the next dividend bit and try one subtract
  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    if (!diff[DEN_W]) begin
      rem_nxt = diff[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // pulse done after the last quotient bit
      done_r <= !start && busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/rgme_chk.sv =====
// Port-level checks for range_gated_multirate_ewma, attached by bind.
// Depends on rgme_pkg for default widths.
`timescale 1ns / 1ps

module rgme_chk #(
  parameter int DIST_BITS = rgme_pkg::DIST_BITS_DEF,
  parameter int TIME_BITS = rgme_pkg::TIME_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_valid_res,
  input logic [DIST_BITS-1:0] out_value,
  input logic [DIST_BITS-1:0] out_filtered
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_valid_res) &&
    $stable(out_value) && $stable(out_filtered))
    else $error("stalled result changed");

  // One item at a time: an accepted item closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accept");

  // Reset empties the output and opens the input
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // A new result only follows a cycle in which the block was busy
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work");

endmodule

bind range_gated_multirate_ewma rgme_chk #(
  .DIST_BITS(DIST_BITS),
  .TIME_BITS(TIME_BITS)
) u_rgme_chk (.*);

// ===== test/range_gated_multirate_ewma_tb.sv =====
// Self-checking testbench for range_gated_multirate_ewma: a directed table, then
// random phases under several register settings, checked by an in-bench predictor.
// Depends on rgme_pkg and the range_gated_multirate_ewma RTL only.
`timescale 1ns / 1ps

module range_gated_multirate_ewma_tb;
  import rgme_pkg::*;

  localparam int DIST_W          = DIST_BITS_DEF;
  localparam int TIME_W          = TIME_BITS_DEF;
  localparam int RESET_CYCLES    = 9;
  localparam int SQUEEZE_CYCLES  = 400;
  localparam int DRAIN_CYCLES    = 60;
  localparam int MAX_REPORTS     = 10;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic              valid_res;
    logic [DIST_W-1:0] value;
    logic [DIST_W-1:0] filtered;
  } range_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  // One line of the directed table: a register write or a sample, with an
  // optional hand-typed result that replaces the predicted one.
  typedef struct {
    row_kind_t         kind;
    cfg_reg_t          reg_sel;
    logic [23:0]       wdata;
    logic [DIST_W-1:0] distance;
    logic [TIME_W-1:0] now_us;
    bit                typed;
    range_result_t     result;
  } table_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [DIST_W-1:0]     in_distance = '0;
  logic [TIME_W-1:0]     in_now_us = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_valid_res;
  logic [DIST_W-1:0]     out_value;
  logic [DIST_W-1:0]     out_filtered;

  range_gated_multirate_ewma dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_distance  (in_distance),
    .in_now_us    (in_now_us),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_valid_res(out_valid_res),
    .out_value    (out_value),
    .out_filtered (out_filtered)
  );

  always #2 clk = ~clk;

  // Predictor copy of the register file, loaded with the reset defaults
  logic [RANGE_W-1:0] range_hi  = MAX_RANGE_RST;
  logic [RANGE_W-1:0] range_lo  = MIN_RANGE_RST;
  logic [TAU_W-1:0]   tau_us    = TAU_RST;
  logic [TAU_W-1:0]   gap_limit = TIMEOUT_RST;

  // Predictor copy of the filter state
  logic              track_valid = 1'b0;
  logic [DIST_W-1:0] track_raw   = '0;
  logic [DIST_W-1:0] track_ewma  = '0;
  logic [TIME_W-1:0] track_time  = '0;

  range_result_t pending_results[$];
  table_row_t    directed_rows[$];

  // Shared knobs between the stimulus, the receiver and the watchdog
  bit                idle_on = 1'b1;
  bit                squeeze_go = 1'b0;
  int unsigned       ready_hold = 0;
  logic [TIME_W-1:0] clock_us = '0;
  longint            cycle_count = 0;

  int unsigned n_samples = 0;
  int unsigned n_in_range = 0;
  int unsigned n_smoothed = 0;
  int unsigned n_results = 0;
  int unsigned n_writes = 0;
  int unsigned n_errors = 0;

  // Advance the filter state by one sample and return the result it reports.
  // Out-of-range samples touch only the valid flag; a restart loads the raw
  // distance; otherwise step by diff*dt/(tau+dt), truncated toward zero.
  function automatic range_result_t ewma_predict(input logic [DIST_W-1:0] d,
                                                 input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] dt;
    logic              prev_valid;
    longint            diff;
    longint            num;
    longint            den;
    longint            step_size;
    range_result_t     res;
    dt = t - track_time;
    if (d < range_hi && d > range_lo) begin
      prev_valid  = track_valid;
      track_raw   = d;
      track_valid = 1'b1;
      track_time  = t;
      n_in_range++;
      if (!prev_valid || dt == '0 || dt >= gap_limit || tau_us == '0) begin
        track_ewma = d;
      end else begin
        // dt is below the timeout here, so it fits in 24 bits
        diff       = $signed({44'd0, d}) - $signed({44'd0, track_ewma});
        num        = diff * $signed({32'd0, dt});
        den        = $signed({40'd0, tau_us}) + $signed({32'd0, dt});
        step_size  = num / den;
        track_ewma = DIST_W'($signed({44'd0, track_ewma}) + step_size);
        n_smoothed++;
      end
    end else begin
      track_valid = 1'b0;
    end
    res.valid_res = track_valid;
    res.value     = track_raw;
    res.filtered  = track_ewma;
    return res;
  endfunction

  // Mostly no idle cycle, some short ones and a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (!idle_on || r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // Favor distances inside the window so the filter path gets exercised;
  // the rest is full-range noise and the exact window edges.
  function automatic logic [DIST_W-1:0] gen_distance();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75 && range_hi > range_lo + 1)
      return DIST_W'($urandom_range(range_hi - 1, range_lo + 1));
    if (r < 87) return DIST_W'($urandom());
    case ($urandom_range(3))
      0:       return range_lo;
      1:       return range_hi;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Advance the sample clock by a step drawn to hit zero steps, small steps,
  // steps around the timeout and arbitrary jumps that wrap the counter.
  function automatic logic [TIME_W-1:0] gen_time();
    int unsigned       r;
    logic [TIME_W-1:0] dt;
    r = $urandom_range(99);
    if (r < 8)       dt = '0;
    else if (r < 22) dt = $urandom_range(16, 1);
    else if (r < 32) dt = TIME_W'(gap_limit) + $urandom_range(2) - 1;
    else if (r < 40) dt = $urandom();
    else if (gap_limit > 1) dt = $urandom_range(gap_limit - 1, 1);
    else             dt = $urandom_range(1000, 1);
    clock_us = clock_us + dt;
    return clock_us;
  endfunction

  // Write one register and mirror it into the predictor, masked to its width
  task automatic write_reg(input cfg_reg_t sel, input logic [23:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= data;
    case (sel)
      REG_MAX_RANGE:  range_hi  = data[RANGE_W-1:0];
      REG_MIN_RANGE:  range_lo  = data[RANGE_W-1:0];
      REG_TIME_CONST: tau_us    = data[TAU_W-1:0];
      REG_TIMEOUT:    gap_limit = data[TAU_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one item and hold it until accepted, then log its expected result.
  // Valid stays high into the next item when no gap is drawn.
  task automatic offer_sample(input logic [DIST_W-1:0] d, input logic [TIME_W-1:0] t,
                              input bit typed, input range_result_t want);
    range_result_t pred;
    int unsigned   gap;
    in_valid    <= 1'b1;
    in_distance <= d;
    in_now_us   <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = ewma_predict(d, t);
    pending_results.push_back(typed ? want : pred);
    n_samples++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_row(input row_kind_t kind, input cfg_reg_t sel, input logic [23:0] data,
                         input logic [DIST_W-1:0] d, input logic [TIME_W-1:0] t,
                         input bit typed, input logic v, input logic [DIST_W-1:0] raw,
                         input logic [DIST_W-1:0] filt);
    table_row_t row;
    row.kind     = kind;
    row.reg_sel  = sel;
    row.wdata    = data;
    row.distance = d;
    row.now_us   = t;
    row.typed    = typed;
    row.result   = '{valid_res: v, value: raw, filtered: filt};
    directed_rows.push_back(row);
  endtask

  // One random phase: reprogram every register while idle, then stream items
  task automatic run_phase(input logic [23:0] hi, input logic [23:0] lo,
                           input logic [23:0] tau, input logic [23:0] tmo,
                           input int unsigned count, input bit idle, input bit squeeze);
    settle();
    write_reg(REG_MAX_RANGE, hi);
    write_reg(REG_MIN_RANGE, lo);
    write_reg(REG_TIME_CONST, tau);
    write_reg(REG_TIMEOUT, tmo);
    idle_on = idle;
    // Hold the result side off while items keep coming, so the input backs up
    if (squeeze) squeeze_go = 1'b1;
    repeat (count) offer_sample(gen_distance(), gen_time(), 1'b0, '0);
  endtask

  // Receiver: check each accepted result against the oldest expectation, then
  // pick out_ready for the next cycle (random stalls or a long hold-off).
  always @(posedge clk) begin : result_side
    range_result_t want;
    range_result_t got;
    got = '{valid_res: out_valid_res, value: out_value, filtered: out_filtered};
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("ERROR: unexpected result %0d: valid_res=%0d value=%0d filtered=%0d",
                   n_results, got.valid_res, got.value, got.filtered);
      end else begin
        want = pending_results.pop_front();
        if (got.valid_res !== want.valid_res || got.value !== want.value ||
            got.filtered !== want.filtered) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display({"ERROR: result %0d: expected valid_res=%0d value=%0d filtered=%0d,",
                      " got valid_res=%0d value=%0d filtered=%0d"},
                     n_results, want.valid_res, want.value, want.filtered,
                     got.valid_res, got.value, got.filtered);
        end
      end
    end
    if (squeeze_go) begin
      squeeze_go = 1'b0;
      ready_hold = SQUEEZE_CYCLES;
    end else if (ready_hold == 0 && $urandom_range(99) < 30) begin
      ready_hold = pick_gap();
    end
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: end the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    logic [23:0] hi;
    logic [23:0] lo;
    logic [23:0] base;

    // Directed table. Hand-typed results are reset state, restarts and edges.
    // Reset defaults: window (1, 5120), tau 100000, timeout 250000.
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd0,      32'd0,      1, 0, 0, 0);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd1,      32'd10,     1, 0, 0, 0);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd5120,   32'd20,     1, 0, 0, 0);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'hFFFFF,  32'd30,     1, 0, 0, 0);
    // first valid sample after invalid ones restarts the filter
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd2,      32'd100,    1, 1, 2, 2);
    // zero time step restarts
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd5119,   32'd100,    1, 1, 5119, 5119);
    // gap exactly at the timeout restarts
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd2,      32'd250100, 1, 1, 2, 2);
    // filtered steps, upward, downward with a step that truncates to zero, long gap
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd5119,   32'd350100, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd2,      32'd350101, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd3000,   32'd600100, 0, 0, 0, 0);
    // huge gap restarts, then a step across the counter wrap
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd4000,   32'hFFFFFFF0, 1, 1, 4000, 4000);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd1000,   32'h10,     0, 0, 0, 0);
    // out of range keeps the stored values
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd6000,   32'h20,     0, 0, 0, 0);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd1500,   32'h30,     1, 1, 1500, 1500);
    // zero time constant disables filtering
    add_row(ROW_WRITE,  REG_TIME_CONST, 24'd0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd100,    32'h40,     1, 1, 100, 100);
    // zero timeout restarts every valid sample
    add_row(ROW_WRITE,  REG_TIME_CONST, 24'hFFFFFF, 0, 0, 0, 0, 0, 0);
    add_row(ROW_WRITE,  REG_TIMEOUT,    24'd0,      0, 0, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd200,    32'h50,     1, 1, 200, 200);
    // widest window, largest tau and timeout
    add_row(ROW_WRITE,  REG_TIMEOUT,    24'hFFFFFF, 0, 0, 0, 0, 0, 0);
    add_row(ROW_WRITE,  REG_MAX_RANGE,  24'hFFFFF,  0, 0, 0, 0, 0, 0);
    add_row(ROW_WRITE,  REG_MIN_RANGE,  24'd0,      0, 0, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'hFFFFE,  32'h60,     0, 0, 0, 0);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'hFFFFF,  32'h70,     0, 0, 0, 0);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd0,      32'h80,     0, 0, 0, 0);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd1,      32'h90,     1, 1, 1, 1);
    // empty windows: equal bounds, then crossed bounds
    add_row(ROW_WRITE,  REG_MIN_RANGE,  24'd500,    0, 0, 0, 0, 0, 0);
    add_row(ROW_WRITE,  REG_MAX_RANGE,  24'd500,    0, 0, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd500,    32'hA0,     0, 0, 0, 0);
    add_row(ROW_WRITE,  REG_MIN_RANGE,  24'd600,    0, 0, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd550,    32'hB0,     0, 0, 0, 0);
    // upper data bits above a range register's width must be dropped
    add_row(ROW_WRITE,  REG_MAX_RANGE,  24'hF01400, 0, 0, 0, 0, 0, 0);
    add_row(ROW_WRITE,  REG_MIN_RANGE,  24'd1,      0, 0, 0, 0, 0, 0);
    add_row(ROW_WRITE,  REG_TIME_CONST, 24'd100000, 0, 0, 0, 0, 0, 0);
    add_row(ROW_WRITE,  REG_TIMEOUT,    24'd250000, 0, 0, 0, 0, 0, 0);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd5119,   32'hC0,     1, 1, 5119, 5119);
    add_row(ROW_SAMPLE, REG_MAX_RANGE, 0, 20'd5120,   32'hD0,     1, 0, 5119, 5119);

    // Hold reset, then release it on a clock edge
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].wdata);
      end else begin
        offer_sample(directed_rows[i].distance, directed_rows[i].now_us,
                     directed_rows[i].typed, directed_rows[i].result);
      end
    end
    clock_us = 32'hD0;

    // Random phases: defaults under back-pressure, extremes with no idling,
    // short tau, no filtering, zero and unit timeout, a one-value window,
    // then fully random settings.
    run_phase(24'd5120, 24'd1, 24'd100000, 24'd250000, 220, 1, 1);
    run_phase(24'hFFFFF, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 200, 0, 0);
    run_phase(24'($urandom_range(20'hFFFFF, 1000)), 24'($urandom_range(500)),
              24'($urandom_range(64, 1)), 24'($urandom_range(100000, 1000)), 200, 1, 0);
    run_phase(24'd5120, 24'd1, 24'd0, 24'd250000, 200, 1, 0);
    run_phase(24'hFFFFF, 24'd0, 24'($urandom_range(24'hFFFFFF)), 24'd0, 120, 1, 0);
    run_phase(24'hFFFFF, 24'd0, 24'($urandom_range(5000)), 24'd1, 80, 1, 0);
    base = 24'($urandom_range(20'hFFFF0));
    run_phase(24'(base + 2), base, 24'($urandom_range(1000, 1)), 24'd5000, 150, 1, 0);
    hi = 24'($urandom_range(20'hFFFFF));
    lo = 24'($urandom_range(hi));
    run_phase(hi, lo, 24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF, 1)),
              250, 1, 1);

    // Drain, then allow for the divider latency before judging
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d samples (%0d in range, %0d filter steps), %0d results,",
             n_samples, n_in_range, n_smoothed, n_results);
    $display("%0d register writes and %0d errors in %0d cycles",
             n_writes, n_errors, cycle_count);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== range_gated_multirate_ewma.f =====
rtl/rgme_pkg.sv
rtl/rgme_div.sv
rtl/range_gated_multirate_ewma.sv
rtl/rgme_chk.sv
test/range_gated_multirate_ewma_tb.sv
